// ----- rtl/m61_pkg.sv -----
// ----------------------------------------------------------------------------
// m61_pkg
// Shared types, constants and helpers for the GF(2^61-1) arithmetic unit.
// ----------------------------------------------------------------------------
package m61_pkg;

  localparam int unsigned FW = 61;
  localparam int unsigned EW = 64;
  localparam int unsigned HW = 32;

  localparam logic [FW-1:0] FIELD_P = {FW{1'b1}};
  localparam logic [EW-1:0] INV_EXP = {{(EW-FW){1'b0}}, FIELD_P} - 64'd2;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_NEG = 3'd2;
  localparam logic [2:0] OP_MUL = 3'd3;
  localparam logic [2:0] OP_POW = 3'd4;
  localparam logic [2:0] OP_INV = 3'd5;
  localparam logic [2:0] OP_DIV = 3'd6;

  typedef enum logic [1:0] {
    MSEL_AB,
    MSEL_ACC,
    MSEL_SQR,
    MSEL_AINV
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     alu;
    logic     pow_init;
    logic     mul_start;
    mul_sel_t mul_sel;
    logic     wr_acc;
    logic     wr_base;
    logic     wr_t_mul;
    logic     wr_t_acc;
    logic     exp_shift;
    logic     res_ld;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       exp_zero;
    logic       exp_bit0;
    logic       exp_last;
    logic       mul_done;
  } dp_stat_t;

  // x < 2p: one conditional subtract gives the residue
  function automatic logic [FW-1:0] reduce_once(input logic [FW:0] x);
    logic [FW:0] d;
    d = x - {1'b0, FIELD_P};
    if (x >= {1'b0, FIELD_P}) begin
      return d[FW-1:0];
    end
    return x[FW-1:0];
  endfunction

endpackage

// ----- rtl/m61_mul.sv -----
// ----------------------------------------------------------------------------
// m61_mul
// Multi-cycle modular multiplier: four 32x32 partial products, fold, reduce.
// ----------------------------------------------------------------------------
module m61_mul (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [m61_pkg::FW-1:0] x,
  input  logic [m61_pkg::FW-1:0] y,
  output logic                   done,
  output logic [m61_pkg::FW-1:0] prod
);
  import m61_pkg::*;

  localparam logic [2:0] PH_ISSUE_LAST = 3'd3;
  localparam logic [2:0] PH_FOLD       = 3'd5;
  localparam logic [2:0] PH_RED        = 3'd6;
  localparam int unsigned PW = 2 * FW;

  logic [FW-1:0]   x_r, y_r;
  logic [2:0]      ph_r;
  logic            busy_r, pp_v_r, done_r;
  logic [1:0]      pp_sel_r;
  logic [2*HW-1:0] pp_r;
  logic [PW-1:0]   acc_r;
  logic [FW:0]     sum_r;
  logic [FW-1:0]   res_r;

  logic [HW-1:0]   xs, ys;
  logic [2*HW-1:0] mprod;
  logic [PW-1:0]   pp_ext;

  always_comb begin
    xs = ph_r[1] ? {{(2*HW-FW){1'b0}}, x_r[FW-1:HW]} : x_r[HW-1:0];
    ys = ph_r[0] ? {{(2*HW-FW){1'b0}}, y_r[FW-1:HW]} : y_r[HW-1:0];
    mprod = xs * ys;
    case (pp_sel_r) inside
      2'd0:       pp_ext = {{(PW-2*HW){1'b0}}, pp_r};
      2'd1, 2'd2: pp_ext = {{(PW-3*HW){1'b0}}, pp_r, {HW{1'b0}}};
      default:    pp_ext = {pp_r[PW-2*HW-1:0], {(2*HW){1'b0}}};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pp_v_r <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= 3'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        pp_v_r <= 1'b0;
        ph_r   <= 3'd0;
      end else if (busy_r) begin
        ph_r   <= ph_r + 3'd1;
        pp_v_r <= (ph_r <= PH_ISSUE_LAST);
        if (ph_r == PH_RED) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= x;
      y_r   <= y;
      acc_r <= '0;
    end else if (busy_r) begin
      pp_r     <= mprod;
      pp_sel_r <= ph_r[1:0];
      if (pp_v_r) begin
        acc_r <= acc_r + pp_ext;
      end
      if (ph_r == PH_FOLD) begin
        sum_r <= {1'b0, acc_r[FW-1:0]} + {1'b0, acc_r[PW-1:FW]};
      end
      if (ph_r == PH_RED) begin
        res_r <= reduce_once(sum_r);
      end
    end
  end

  assign done = done_r;
  assign prod = res_r;

endmodule

// ----- rtl/m61_dp.sv -----
// ----------------------------------------------------------------------------
// m61_dp
// Datapath: operand capture and reduction, add/sub/neg, exponent and
// accumulator registers, shared multiplier, output registers.
// ----------------------------------------------------------------------------
module m61_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  m61_pkg::dp_cmd_t       cmd,
  output m61_pkg::dp_stat_t      stat,
  input  logic [2:0]             in_op,
  input  logic [m61_pkg::FW-1:0] in_operand_a,
  input  logic [m61_pkg::EW-1:0] in_operand_b,
  output logic [m61_pkg::FW-1:0] out_value,
  output logic                   out_a_equals_b,
  output logic                   out_a_less_than_b
);
  import m61_pkg::*;

  logic [2:0]    op_r;
  logic [FW-1:0] a_r, b_r, acc_r, base_r, val_r;
  logic [EW-1:0] exp_r;
  logic [FW:0]   t_r;
  logic          eq_r, lt_r;

  logic [FW-1:0] a_red, b_red;
  logic [FW:0]   b_fold;
  logic [FW-1:0] mx, my, mprod;
  logic          mdone;

  always_comb begin
    a_red  = (in_operand_a == FIELD_P) ? '0 : in_operand_a;
    b_fold = {{(FW+1-(EW-FW)){1'b0}}, in_operand_b[EW-1:FW]}
           + {1'b0, in_operand_b[FW-1:0]};
    b_red  = reduce_once(b_fold);
    case (cmd.mul_sel)
      MSEL_AB:  begin mx = a_r;    my = b_r;    end
      MSEL_ACC: begin mx = acc_r;  my = base_r; end
      MSEL_SQR: begin mx = base_r; my = base_r; end
      default:  begin mx = a_r;    my = acc_r;  end
    endcase
  end

  m61_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .x     (mx),
    .y     (my),
    .done  (mdone),
    .prod  (mprod)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_op;
      a_r   <= a_red;
      b_r   <= b_red;
      exp_r <= in_operand_b;
    end
    if (cmd.alu) begin
      case (op_r)
        OP_ADD:  t_r <= {1'b0, a_r} + {1'b0, b_r};
        OP_SUB:  t_r <= {1'b0, a_r} + {1'b0, FIELD_P} - {1'b0, b_r};
        OP_NEG:  t_r <= {1'b0, FIELD_P} - {1'b0, a_r};
        default: t_r <= '0;
      endcase
    end
    if (cmd.pow_init) begin
      acc_r  <= {{(FW-1){1'b0}}, 1'b1};
      base_r <= (op_r == OP_DIV) ? b_r : a_r;
      if (op_r != OP_POW) begin
        exp_r <= INV_EXP;
      end
    end
    if (cmd.wr_acc)    acc_r  <= mprod;
    if (cmd.wr_base)   base_r <= mprod;
    if (cmd.wr_t_mul)  t_r    <= {1'b0, mprod};
    if (cmd.wr_t_acc)  t_r    <= {1'b0, acc_r};
    if (cmd.exp_shift) exp_r  <= {1'b0, exp_r[EW-1:1]};
    if (cmd.res_ld) begin
      val_r <= reduce_once(t_r);
      eq_r  <= (a_r == b_r);
      lt_r  <= (a_r < b_r);
    end
  end

  always_comb begin
    stat.op       = op_r;
    stat.exp_zero = (exp_r == '0);
    stat.exp_bit0 = exp_r[0];
    stat.exp_last = (exp_r[EW-1:1] == '0);
    stat.mul_done = mdone;
  end

  assign out_value         = val_r;
  assign out_a_equals_b    = eq_r;
  assign out_a_less_than_b = lt_r;

endmodule

// ----- rtl/m61_ctrl.sv -----
// ----------------------------------------------------------------------------
// m61_ctrl
// Controller: item handshake, op dispatch, square-and-multiply sequencing,
// output register valid.
// ----------------------------------------------------------------------------
module m61_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output m61_pkg::dp_cmd_t  cmd,
  input  m61_pkg::dp_stat_t stat
);
  import m61_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PREP  = 7'b0000010,
    S_ROUND = 7'b0000100,
    S_MACC  = 7'b0001000,
    S_MSQR  = 7'b0010000,
    S_MFIN  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        case (stat.op) inside
          OP_MUL: begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = MSEL_AB;
            state_nxt     = S_MFIN;
          end
          OP_POW, OP_INV, OP_DIV: begin
            cmd.pow_init = 1'b1;
            state_nxt    = S_ROUND;
          end
          default: begin
            cmd.alu   = 1'b1;
            state_nxt = S_OUT;
          end
        endcase
      end
      S_ROUND: begin
        if (stat.exp_zero) begin
          if (stat.op == OP_DIV) begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = MSEL_AINV;
            state_nxt     = S_MFIN;
          end else begin
            cmd.wr_t_acc = 1'b1;
            state_nxt    = S_OUT;
          end
        end else if (stat.exp_bit0) begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MSEL_ACC;
          state_nxt     = S_MACC;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MSEL_SQR;
          state_nxt     = S_MSQR;
        end
      end
      S_MACC: begin
        if (stat.mul_done) begin
          cmd.wr_acc = 1'b1;
          if (stat.exp_last) begin
            // top bit: final square is not needed
            cmd.exp_shift = 1'b1;
            state_nxt     = S_ROUND;
          end else begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = MSEL_SQR;
            state_nxt     = S_MSQR;
          end
        end
      end
      S_MSQR: begin
        if (stat.mul_done) begin
          cmd.wr_base   = 1'b1;
          cmd.exp_shift = 1'b1;
          state_nxt     = S_ROUND;
        end
      end
      S_MFIN: begin
        if (stat.mul_done) begin
          cmd.wr_t_mul = 1'b1;
          state_nxt    = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.res_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.res_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- rtl/mersenne61_field_alu_core.sv -----
// ----------------------------------------------------------------------------
// mersenne61_field_alu_core
// Arithmetic unit over GF(p), p = 2^61-1, with compare flags.
// ----------------------------------------------------------------------------
// One item at a time; a finished result waits in the output register while
// the next item is taken. Every modular multiply runs on one shared 32x32
// multiplier, four partial products then a fold and a reduce. Power scans
// the exponent from its lowest bit: each bit up to the highest set bit
// squares the base, and each set bit first multiplies the base into the
// accumulator; the highest set bit needs no square. Inverse runs the fixed
// exponent p-2; divide adds one multiply to that.
// Operands are reduced mod p on entry and results are fully reduced.
// Inverse and quotient of zero give 0.
module mersenne61_field_alu_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [2:0]             in_op,
  input  logic [m61_pkg::FW-1:0] in_operand_a,
  input  logic [m61_pkg::EW-1:0] in_operand_b,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [m61_pkg::FW-1:0] out_value,
  output logic                   out_a_equals_b,
  output logic                   out_a_less_than_b
);
  import m61_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  m61_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  m61_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_op             (in_op),
    .in_operand_a      (in_operand_a),
    .in_operand_b      (in_operand_b),
    .out_value         (out_value),
    .out_a_equals_b    (out_a_equals_b),
    .out_a_less_than_b (out_a_less_than_b)
  );

endmodule

// ----- rtl/m61_checker.sv -----
// ----------------------------------------------------------------------------
// m61_checker
// Port-level checks for the GF(2^61-1) arithmetic unit, bound to the core.
// ----------------------------------------------------------------------------
module m61_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic [2:0]             in_op,
  input logic [m61_pkg::FW-1:0] in_operand_a,
  input logic [m61_pkg::EW-1:0] in_operand_b,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [m61_pkg::FW-1:0] out_value,
  input logic                   out_a_equals_b,
  input logic                   out_a_less_than_b
);
  import m61_pkg::*;

  logic in_item_seen;
  assign in_item_seen = in_valid && !in_stall;

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_op) && $stable(in_operand_a)
                             && $stable(in_operand_b))
    else $error("stalled input item dropped or changed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value))
    else $error("stalled result dropped or changed");

  a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_value != FIELD_P)
    else $error("result not fully reduced");

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_a_equals_b && out_a_less_than_b))
    else $error("equal and less-than flags both set");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_item_seen |=> in_stall)
    else $error("second item taken while one is in work");

endmodule

bind mersenne61_field_alu_core m61_checker u_m61_checker (.*);
